### sv/iuhb_pkg.sv
// Shared types and constants for the IPv4/UDP header builder.
// No dependencies; every other file of the block refers to this package.
package iuhb_pkg;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  // Dividend of the offset remainder is offset + 1, one bit wider than a field
  localparam int unsigned DVD_W      = FIELD_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(DVD_W);
  // Raw checksum sum: constant words, four address halves, length and id
  localparam int unsigned CSUM_W     = FIELD_W + 3;

  localparam logic [FIELD_W-1:0] HDR_WORD0   = 16'h4500;  // version 4, IHL 5, TOS 0
  localparam logic [FIELD_W-1:0] HDR_WORD4   = 16'h0811;  // TTL 8, protocol UDP
  localparam logic [FIELD_W-1:0] UDP_HDR_LEN = 16'd8;
  localparam logic [FIELD_W-1:0] IP_HDR_LEN  = 16'd20;
  localparam logic [FIELD_W-1:0] SPAN_RESET  = 16'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ADDR  = 3'd0,
    CFG_DST_ADDR  = 3'd1,
    CFG_DST_PORT  = 3'd2,
    CFG_BASE_PORT = 3'd3,
    CFG_PORT_SPAN = 3'd4
  } cfg_idx_t;

  // Item between the length/counter stage and the checksum stage
  typedef struct packed {
    logic [FIELD_W-1:0] total_length;
    logic [FIELD_W-1:0] udp_length;
    logic [FIELD_W-1:0] identification;
    logic [FIELD_W-1:0] sport_ofs;
  } stage_t;

  typedef struct packed {
    logic               start;
    logic [DVD_W-1:0]   dividend;
    logic [FIELD_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [FIELD_W-1:0] rem;
  } rem_rsp_t;

endpackage

### sv/iuhb_if.sv
// Valid/ready channel interfaces of the header builder.
// Depends on iuhb_pkg for the field width.
interface iuhb_in_if;
  logic                         valid;
  logic                         ready;
  logic [iuhb_pkg::FIELD_W-1:0] payload_length;

  modport source (output valid, output payload_length, input ready);
  modport sink   (input valid, input payload_length, output ready);
endinterface

interface iuhb_out_if;
  logic                         valid;
  logic                         ready;
  logic [iuhb_pkg::FIELD_W-1:0] total_length;
  logic [iuhb_pkg::FIELD_W-1:0] identification;
  logic [iuhb_pkg::FIELD_W-1:0] header_checksum;
  logic [iuhb_pkg::FIELD_W-1:0] source_port;
  logic [iuhb_pkg::FIELD_W-1:0] dest_port_out;
  logic [iuhb_pkg::FIELD_W-1:0] udp_length;

  modport source (output valid, output total_length, output identification,
                  output header_checksum, output source_port, output dest_port_out,
                  output udp_length, input ready);
  modport sink   (input valid, input total_length, input identification,
                  input header_checksum, input source_port, input dest_port_out,
                  input udp_length, output ready);
endinterface

### sv/iuhb_rem.sv
// Restoring remainder unit, one dividend bit per cycle.
// Used to renormalize the source port offset after the span changes. Uses iuhb_pkg.
module iuhb_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  iuhb_pkg::rem_req_t req,
  output iuhb_pkg::rem_rsp_t rsp
);

  logic                             busy_r, busy_nxt;
  logic [iuhb_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [iuhb_pkg::DVD_W-1:0]       dvd_r, dvd_nxt;
  logic [iuhb_pkg::FIELD_W-1:0]     div_r, div_nxt;
  logic [iuhb_pkg::FIELD_W-1:0]     rem_r, rem_nxt;
  logic [iuhb_pkg::FIELD_W:0]       trial;
  logic [iuhb_pkg::FIELD_W-1:0]     step_rem;

  always_comb begin
    trial    = {rem_r, dvd_r[iuhb_pkg::DVD_W-1]};
    step_rem = (trial >= {1'b0, div_r}) ?
               iuhb_pkg::FIELD_W'(trial - {1'b0, div_r}) :
               trial[iuhb_pkg::FIELD_W-1:0];

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      // a zero divisor needs no remainder: drop any run in progress
      busy_nxt = (req.divisor != '0);
      cnt_nxt  = iuhb_pkg::DIV_CNT_W'(iuhb_pkg::DVD_W - 1);
      dvd_nxt  = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[iuhb_pkg::DVD_W-2:0], 1'b0};
      rem_nxt  = step_rem;
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = busy_r && (cnt_r == '0) && !req.start;
  assign rsp.rem  = step_rem;

endmodule

### sv/iuhb_hdr.sv
// Checksum and source port stage with the result register.
// Takes a stage_t item from the front stage; uses iuhb_pkg and iuhb_out_if.
module iuhb_hdr (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           s1_valid,
  output logic                           s1_ready,
  input  iuhb_pkg::stage_t               s1_item,
  input  logic [iuhb_pkg::CSUM_W-1:0]    addr_sum,
  input  logic [iuhb_pkg::FIELD_W-1:0]   sport_base,
  input  logic [iuhb_pkg::FIELD_W-1:0]   dst_port,
  iuhb_out_if.source                     out_if
);

  logic                             valid_r, valid_nxt;
  logic [iuhb_pkg::FIELD_W-1:0]     tot_r, id_r, csum_r, sport_r, dport_r, ulen_r;
  logic [iuhb_pkg::CSUM_W-1:0]      raw_sum;
  logic [iuhb_pkg::FIELD_W:0]       fold1, fold2;
  logic [iuhb_pkg::FIELD_W-1:0]     csum;
  logic [iuhb_pkg::FIELD_W-1:0]     sport;

  always_comb begin
    raw_sum = addr_sum
            + iuhb_pkg::CSUM_W'(s1_item.total_length)
            + iuhb_pkg::CSUM_W'(s1_item.identification);
    // fold the carries back in twice, then invert
    fold1 = (iuhb_pkg::FIELD_W+1)'(raw_sum[iuhb_pkg::CSUM_W-1:iuhb_pkg::FIELD_W])
          + {1'b0, raw_sum[iuhb_pkg::FIELD_W-1:0]};
    fold2 = (iuhb_pkg::FIELD_W+1)'(fold1[iuhb_pkg::FIELD_W])
          + {1'b0, fold1[iuhb_pkg::FIELD_W-1:0]};
    csum  = ~fold2[iuhb_pkg::FIELD_W-1:0];
    sport = sport_base + s1_item.sport_ofs;
  end

  assign s1_ready  = !valid_r || out_if.ready;
  assign valid_nxt = s1_valid || (valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (s1_valid && s1_ready) begin
      tot_r   <= s1_item.total_length;
      id_r    <= s1_item.identification;
      csum_r  <= csum;
      sport_r <= sport;
      dport_r <= dst_port;
      ulen_r  <= s1_item.udp_length;
    end
  end

  assign out_if.valid           = valid_r;
  assign out_if.total_length    = tot_r;
  assign out_if.identification  = id_r;
  assign out_if.header_checksum = csum_r;
  assign out_if.source_port     = sport_r;
  assign out_if.dest_port_out   = dport_r;
  assign out_if.udp_length      = ulen_r;

endmodule

### sv/ipv4_udp_header_builder.sv
// Top level of the IPv4/UDP header builder: config registers, counters, front stage.
// Depends on iuhb_pkg, iuhb_if, iuhb_rem and iuhb_hdr.
//
//   port      dir  flow        payload
//   in_if     in   valid/ready payload_length
//   out_if    out  valid/ready total_length, identification, header_checksum,
//                              source_port, dest_port_out, udp_length
//   cfg_*     in   write only  cfg_index selects register, cfg_wdata
//
// Two register stages: lengths and counters at accept, checksum and port sum
// into the result register. One item per cycle while the output takes items and the remainder unit is idle.
// A write to the port span with a nonzero value runs the remainder unit;
// no item is accepted while it is busy.
// Reset is synchronous; span resets to 4096, other config, counters and valids to zero.
// A full, stalled result register holds its item and the input; an item
// already in the front stage waits behind it.
module ipv4_udp_header_builder (
  input  logic                               clk,
  input  logic                               rst_n,
  iuhb_in_if.sink                            in_if,
  iuhb_out_if.source                         out_if,
  input  logic                               cfg_we,
  input  logic [iuhb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iuhb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [iuhb_pkg::ADDR_W-1:0]   src_addr_r, dst_addr_r;
  logic [iuhb_pkg::FIELD_W-1:0]  dst_port_r, sport_base_r, span_r;
  logic [iuhb_pkg::CSUM_W-1:0]   addr_sum_r, addr_sum_nxt;
  logic [iuhb_pkg::FIELD_W-1:0]  id_r, id_nxt;
  logic [iuhb_pkg::FIELD_W-1:0]  offset_r, offset_nxt;
  logic                          s1_valid_r, s1_valid_nxt;
  iuhb_pkg::stage_t              s1_item_r, s1_item_nxt;
  logic                          s1_ready;
  logic                          in_acc;
  logic [iuhb_pkg::FIELD_W-1:0]  offset_inc;
  logic [iuhb_pkg::FIELD_W-1:0]  offset_step;
  logic [iuhb_pkg::FIELD_W-1:0]  udp_len;
  iuhb_pkg::rem_req_t            rem_req;
  iuhb_pkg::rem_rsp_t            rem_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r   <= '0;
      dst_addr_r   <= '0;
      dst_port_r   <= '0;
      sport_base_r <= '0;
      span_r       <= iuhb_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (iuhb_pkg::cfg_idx_t'(cfg_index))
        iuhb_pkg::CFG_SRC_ADDR:  src_addr_r   <= cfg_wdata;
        iuhb_pkg::CFG_DST_ADDR:  dst_addr_r   <= cfg_wdata;
        iuhb_pkg::CFG_DST_PORT:  dst_port_r   <= cfg_wdata[iuhb_pkg::FIELD_W-1:0];
        iuhb_pkg::CFG_BASE_PORT: sport_base_r <= cfg_wdata[iuhb_pkg::FIELD_W-1:0];
        iuhb_pkg::CFG_PORT_SPAN: span_r       <= cfg_wdata[iuhb_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  // Constant part of the header checksum, refreshed every cycle
  assign addr_sum_nxt = iuhb_pkg::CSUM_W'(iuhb_pkg::HDR_WORD0)
                      + iuhb_pkg::CSUM_W'(iuhb_pkg::HDR_WORD4)
                      + iuhb_pkg::CSUM_W'(src_addr_r[iuhb_pkg::ADDR_W-1:iuhb_pkg::FIELD_W])
                      + iuhb_pkg::CSUM_W'(src_addr_r[iuhb_pkg::FIELD_W-1:0])
                      + iuhb_pkg::CSUM_W'(dst_addr_r[iuhb_pkg::ADDR_W-1:iuhb_pkg::FIELD_W])
                      + iuhb_pkg::CSUM_W'(dst_addr_r[iuhb_pkg::FIELD_W-1:0]);

  always_ff @(posedge clk) begin
    addr_sum_r <= addr_sum_nxt;
  end

  // Remainder unit renormalizes the offset when the span changes
  always_comb begin
    rem_req.start    = cfg_we &&
                       (iuhb_pkg::cfg_idx_t'(cfg_index) == iuhb_pkg::CFG_PORT_SPAN);
    rem_req.dividend = {1'b0, offset_r} + iuhb_pkg::DVD_W'(1);
    rem_req.divisor  = cfg_wdata[iuhb_pkg::FIELD_W-1:0];
  end

  iuhb_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign in_if.ready = s1_ready && !rem_rsp.busy;
  assign in_acc      = in_if.valid && in_if.ready;

  always_comb begin
    offset_inc  = offset_r + 1'b1;
    // offset stays below a nonzero span, so the wrap is a single compare
    offset_step = ((span_r != '0) && (offset_inc == span_r)) ? '0 : offset_inc;
    udp_len     = in_if.payload_length + iuhb_pkg::UDP_HDR_LEN;

    id_nxt     = id_r;
    offset_nxt = offset_r;
    if (in_acc) begin
      id_nxt     = id_r + 1'b1;
      offset_nxt = offset_step;
    end else if (rem_rsp.done) begin
      // park one below the remainder so the next step lands on it
      offset_nxt = (rem_rsp.rem == '0) ? span_r - 1'b1 : rem_rsp.rem - 1'b1;
    end

    s1_item_nxt.udp_length     = udp_len;
    s1_item_nxt.total_length   = udp_len + iuhb_pkg::IP_HDR_LEN;
    s1_item_nxt.identification = id_r;
    s1_item_nxt.sport_ofs      = offset_step;

    s1_valid_nxt = in_acc || (s1_valid_r && !s1_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r       <= '0;
      offset_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      id_r       <= id_nxt;
      offset_r   <= offset_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_acc) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  iuhb_hdr u_hdr (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_ready   (s1_ready),
    .s1_item    (s1_item_r),
    .addr_sum   (addr_sum_r),
    .sport_base (sport_base_r),
    .dst_port   (dst_port_r),
    .out_if     (out_if)
  );

  // Offset must be back in range once the remainder unit is quiet
  a_offset_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (!rem_rsp.busy && span_r != '0) |-> (offset_r < span_r))
    else $error("port offset out of span");

  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (id_r == $past(id_r) + 1'b1))
    else $error("id counter did not advance on accepted item");

  a_id_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(id_r))
    else $error("id counter moved without an item");

  a_s1_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("front stage lost a stalled item");

endmodule
